>>> sv/isq_pkg.sv
package isq_pkg;

   // table geometry
   localparam int MAX_INTERVALS = 16;
   localparam int IDX_W         = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int COUNT_W       = $clog2(MAX_INTERVALS + 1);
   localparam int ADDR_W        = IDX_W + 1;
   localparam int RAM_DEPTH     = 2 ** ADDR_W;

   // field widths fixed by the interface
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int ENTRY_W     = 2 * VALUE_W;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [COUNT_OUT_W-1:0]    count_out_type;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   // one stored interval
   typedef struct packed {
      value_type left;
      value_type right;
   } entry_type;

   // compare results for one stored entry
   typedef struct packed {
      logic overlap;        // shares at least one point with the insert
      logic hit;            // contains the query point
      logic beyond;         // starts after the insert ends
      logic extends_left;   // reaches below the merged left edge
      logic extends_right;  // reaches above the merged right edge
   } cmp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_FINISH,
      ST_DONE
   } state_type;

endpackage

>>> sv/isq_if.sv
// request channel: one insert or query per beat
interface isq_req_if;
   import isq_pkg::*;

   logic        valid;
   logic        ready;
   logic [0:0]  operation;
   value_type   interval_left;
   value_type   interval_right;
   value_type   query_point;

   modport source (
      output valid, operation, interval_left, interval_right, query_point,
      input  ready
   );
   modport sink (
      input  valid, operation, interval_left, interval_right, query_point,
      output ready
   );
endinterface

// response channel: one result beat per request beat
interface isq_rsp_if;
   import isq_pkg::*;

   logic          valid;
   logic          ready;
   logic [0:0]    in_set;
   logic [0:0]    status;
   count_out_type interval_count;

   modport source (
      output valid, in_set, status, interval_count,
      input  ready
   );
   modport sink (
      input  valid, in_set, status, interval_count,
      output ready
   );
endinterface

>>> sv/isq_ram.sv
// simple dual port RAM, one write and one registered read per cycle
module isq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/isq_cmp.sv
// shared compare unit: checks one stored entry against the current beat
module isq_cmp (
   input  isq_pkg::entry_type entry,
   input  isq_pkg::value_type insert_left,
   input  isq_pkg::value_type insert_right,
   input  isq_pkg::value_type point,
   input  isq_pkg::value_type merge_left,
   input  isq_pkg::value_type merge_right,
   output isq_pkg::cmp_type   flags
);
   import isq_pkg::*;

   value_type entry_left;
   value_type entry_right;

   assign entry_left  = entry.left;
   assign entry_right = entry.right;

   // closed intervals: a shared endpoint counts as overlap
   always_comb begin
      flags.overlap       = (entry_left <= insert_right) && (entry_right >= insert_left);
      flags.hit           = (entry_left <= point) && (point <= entry_right);
      flags.beyond        = entry_left > insert_right;
      flags.extends_left  = entry_left < merge_left;
      flags.extends_right = entry_right > merge_right;
   end

endmodule

>>> sv/interval_set_merge_query.sv
// Sorted set of disjoint closed intervals with merging insert and point query.
//
// req_chan carries one item per beat: operation 0 inserts
// [interval_left, interval_right], operation 1 tests query_point.
// rsp_chan returns exactly one beat per item: in_set, status (1 when an
// insert was dropped because the table is full) and interval_count.
//
// Items are taken one at a time; req_chan.ready is high only while idle.
// The table lives in two banks of one RAM. An item scans the stored entries
// through the single RAM read port, one entry a cycle but for a pause while the
// merged interval is placed, and an insert writes the compacted table into the
// other bank, which becomes active when done unless the insert is dropped.
// An insert goes on to ST_FINISH, via ST_PLACE when the merged interval lands
// ahead of a stored entry; an inverted insert or a query of an empty table
// goes straight to ST_DONE, and the next item waits until its result leaves it.
//
// Reset empties the table at once; RAM contents need no clearing.
// The result sits in an output register; while rsp_chan is stalled the
// block finishes the next item and holds until the register frees up.
module interval_set_merge_query (
   input logic        clock,
   input logic        reset,
   isq_req_if.sink    req_chan,
   isq_rsp_if.source  rsp_chan
);
   import isq_pkg::*;

   state_type     state_ff, state_in;
   logic          bank_ff, bank_in;
   count_type     count_ff, count_in;
   logic          op_query_ff, op_query_in;
   value_type     lo_ff, lo_in;
   value_type     hi_ff, hi_in;
   value_type     point_ff, point_in;
   value_type     ml_ff, ml_in;
   value_type     mr_ff, mr_in;
   idx_type       scan_idx_ff, scan_idx_in;
   count_type     out_idx_ff, out_idx_in;
   logic          absorbed_ff, absorbed_in;
   logic          placed_ff, placed_in;
   logic          hit_ff, hit_in;
   logic          drop_ff, drop_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_in_set_ff, rsp_in_set_in;
   logic          rsp_status_ff, rsp_status_in;
   count_out_type rsp_count_ff, rsp_count_in;

   logic      accept;
   logic      rsp_free;
   entry_type rd_entry;
   logic [ENTRY_W-1:0] rd_data;
   cmp_type   flags;
   count_type next_idx;
   logic      last;
   logic      room;
   logic      stall;
   logic      drop_now;
   logic      rd_en;
   idx_type   rd_idx;
   logic      wr_req;
   logic      wr_en;
   logic      wr_merged;
   entry_type wr_entry;
   addr_type  rd_addr;
   addr_type  wr_addr;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rd_entry = rd_data;
   assign next_idx = count_type'(scan_idx_ff) + count_type'(1);
   assign last     = next_idx >= count_ff;
   assign room     = out_idx_ff < count_type'(MAX_INTERVALS);
   assign drop_now = !absorbed_ff && (count_ff >= count_type'(MAX_INTERVALS));

   // merged interval goes ahead of the first disjoint entry past it
   assign stall = (state_ff == ST_SCAN) && !op_query_ff && !flags.overlap
                  && !placed_ff && flags.beyond;

   isq_cmp u_cmp (
      .entry        (rd_entry),
      .insert_left  (lo_ff),
      .insert_right (hi_ff),
      .point        (point_ff),
      .merge_left   (ml_ff),
      .merge_right  (mr_ff),
      .flags        (flags)
   );

   assign rd_addr = {bank_ff, rd_idx};
   assign wr_addr = {~bank_ff, out_idx_ff[IDX_W-1:0]};

   isq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.operation == OP_QUERY) begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_SCAN;
               end else if (req_chan.interval_left > req_chan.interval_right) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (stall) begin
               state_in = ST_PLACE;
            end else if (last) begin
               state_in = op_query_ff ? ST_DONE : ST_FINISH;
            end
         end
         ST_PLACE: begin
            state_in = last ? ST_FINISH : ST_SCAN;
         end
         ST_FINISH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: RAM port control
   always_comb begin
      rd_en     = 1'b0;
      rd_idx    = '0;
      wr_req    = 1'b0;
      wr_merged = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_en = accept;
         end
         ST_SCAN: begin
            rd_en  = !stall && !last;
            rd_idx = next_idx[IDX_W-1:0];
            if (!op_query_ff && !flags.overlap) begin
               wr_req    = 1'b1;
               wr_merged = stall;
            end
         end
         ST_PLACE: begin
            rd_en  = !last;
            rd_idx = next_idx[IDX_W-1:0];
            wr_req = 1'b1;
         end
         ST_FINISH: begin
            wr_req    = !placed_ff && !drop_now;
            wr_merged = 1'b1;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign wr_en    = wr_req && room;
   assign wr_entry = wr_merged ? entry_type'{left: ml_ff, right: mr_ff} : rd_entry;

   // datapath next values
   always_comb begin
      bank_in       = bank_ff;
      count_in      = count_ff;
      op_query_in   = op_query_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      point_in      = point_ff;
      ml_in         = ml_ff;
      mr_in         = mr_ff;
      scan_idx_in   = scan_idx_ff;
      out_idx_in    = out_idx_ff;
      absorbed_in   = absorbed_ff;
      placed_in     = placed_ff;
      hit_in        = hit_ff;
      drop_in       = drop_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_in_set_in = rsp_in_set_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      if (wr_en) begin
         out_idx_in = out_idx_ff + count_type'(1);
      end
      if (rd_en && (state_ff != ST_IDLE)) begin
         scan_idx_in = next_idx[IDX_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_query_in = req_chan.operation == OP_QUERY;
               lo_in       = req_chan.interval_left;
               hi_in       = req_chan.interval_right;
               point_in    = req_chan.query_point;
               ml_in       = req_chan.interval_left;
               mr_in       = req_chan.interval_right;
               scan_idx_in = '0;
               out_idx_in  = '0;
               absorbed_in = 1'b0;
               placed_in   = 1'b0;
               hit_in      = 1'b0;
               drop_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            if (op_query_ff) begin
               hit_in = hit_ff || flags.hit;
            end else if (flags.overlap) begin
               absorbed_in = 1'b1;
               if (flags.extends_left) begin
                  ml_in = rd_entry.left;
               end
               if (flags.extends_right) begin
                  mr_in = rd_entry.right;
               end
            end
            if (stall) begin
               placed_in = 1'b1;
            end
         end
         ST_PLACE: begin
         end
         ST_FINISH: begin
            // commit the new bank unless the insert is dropped
            drop_in = drop_now;
            if (!drop_now) begin
               bank_in  = ~bank_ff;
               count_in = out_idx_in;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in_set_in = hit_ff;
               rsp_status_in = drop_ff ? STATUS_FULL : STATUS_OK;
               rsp_count_in  = count_out_type'(count_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         placed_ff    <= 1'b0;
         absorbed_ff  <= 1'b0;
         out_idx_ff   <= '0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         placed_ff    <= placed_in;
         absorbed_ff  <= absorbed_in;
         out_idx_ff   <= out_idx_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_query_ff   <= op_query_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      point_ff      <= point_in;
      ml_ff         <= ml_in;
      mr_ff         <= mr_in;
      hit_ff        <= hit_in;
      drop_ff       <= drop_in;
      rsp_in_set_ff <= rsp_in_set_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_chan.ready          = state_ff == ST_IDLE;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.in_set         = rsp_in_set_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.interval_count = rsp_count_ff;

`ifndef SYNTHESIS
   // the live bank is never written
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr[ADDR_W-1] != bank_ff))
      else $error("write into the active bank");

   // the table never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MAX_INTERVALS))
      else $error("stored count above capacity");

   // a dropped insert leaves the table untouched
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && drop_now) |=> ($stable(count_ff) && $stable(bank_ff)))
      else $error("dropped insert changed the table");

   // one insert adds at most one interval
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=>
         ({1'b0, count_ff} <= ({1'b0, $past(count_ff)} + {{COUNT_W{1'b0}}, 1'b1})))
      else $error("insert grew the table by more than one");

   // the merged interval is written at most once per insert
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PLACE) |-> (placed_ff && ($past(state_ff) == ST_SCAN)))
      else $error("merged interval placed twice");
`endif

endmodule
